// ===== design/strain_press_debouncer_core_defines.svh =====
// Assertion macros for the strain press debouncer.
// No dependencies; included by the top level only.
`ifndef STRAIN_PRESS_DEBOUNCER_CORE_DEFINES_SVH
`define STRAIN_PRESS_DEBOUNCER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define SPD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== design/spd_pkg.sv =====
// Shared widths, register indexes and types for the strain press debouncer.
// No dependencies.
package spd_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int DELTA_BITS     = SAMPLE_BITS + 1;
    // Room for 2*delta and -delta at any bit pattern of the delta register.
    localparam int CMP_BITS       = SAMPLE_BITS + 3;
    localparam int CFG_DATA_BITS  = DELTA_BITS;
    localparam int CFG_INDEX_BITS = 2;
    localparam int RUN_BITS       = 8;
    localparam int TOTAL_BITS     = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_DETECT_ENABLE = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IDLE_LEVEL    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DELTA_LEVEL   = 2'd2;

    // The pressed state toggles once the run counter exceeds this.
    localparam logic [RUN_BITS-1:0] RUN_LIMIT = 8'd2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [DELTA_BITS-1:0]  delta_t;
    typedef logic signed [CMP_BITS-1:0]    cmp_word_t;

    // Classification of one sample against the calibration.
    typedef struct packed {
        logic active;      // detection enabled and delta nonzero
        logic in_range;    // ratio inside (-1, 2)
        logic above_one;   // ratio > 1
        logic below_half;  // ratio < 1/2
    } cmp_t;

endpackage

// ===== design/strain_press_debouncer_core.sv =====
// Top level of the strain press debouncer: handshake, input stage, config.
// Depends on spd_pkg, spd_classify, spd_track and the assertion macro header.
//
// Debounced press detector for a load-cell knob. Each signed sample is
// compared with the idle level and the calibrated delta by exact integer
// compares; samples whose ratio (sample - idle) / delta lies outside (-1, 2)
// are dropped, and a run of more than two qualifying samples toggles the
// pressed state, raising a press or release event and counting presses in a
// wrapping 32-bit total.
// Every input transaction yields exactly one result transaction. A sample
// passes the input register, then classify and state update load the result
// register; one transaction per cycle is sustained while the result side
// keeps up. Configuration writes take effect at once and are expected only
// while the block is idle.
`include "strain_press_debouncer_core_defines.svh"

module strain_press_debouncer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [spd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [spd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    // sample channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  spd_pkg::sample_t                    s_sample,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_is_pressed,
    output logic                                m_press_event,
    output logic                                m_release_event,
    output logic [spd_pkg::TOTAL_BITS-1:0]      m_press_total
);

    // Configuration registers.
    logic             enable_reg;
    spd_pkg::sample_t idle_reg;
    spd_pkg::delta_t  delta_reg;

    // Input stage and result valid.
    logic             s1_valid_reg, s1_valid_next;
    spd_pkg::sample_t sample_reg;
    logic             m_valid_reg, m_valid_next;

    logic             out_free;   // result register may be loaded this cycle
    logic             fire;       // input stage moves into result register
    logic             s_accept;
    spd_pkg::cmp_t    cmp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            idle_reg   <= '0;
            delta_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                spd_pkg::CFG_DETECT_ENABLE: enable_reg <= cfg_wdata[0];
                spd_pkg::CFG_IDLE_LEVEL:    idle_reg   <= cfg_wdata[spd_pkg::SAMPLE_BITS-1:0];
                spd_pkg::CFG_DELTA_LEVEL:   delta_reg  <= cfg_wdata;
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // Handshake: the input stage refills in the same cycle it drains, so a
    // transaction can enter every cycle while the result side keeps up.
    assign out_free = !m_valid_reg || m_ready;
    assign fire     = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (fire) begin
            s1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Sample payload, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            sample_reg <= s_sample;
        end
    end

    spd_classify u_classify (
        .sample        (sample_reg),
        .idle_level    (idle_reg),
        .delta_level   (delta_reg),
        .detect_enable (enable_reg),
        .cmp           (cmp)
    );

    spd_track u_track (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .cmp           (cmp),
        .is_pressed    (m_is_pressed),
        .press_event   (m_press_event),
        .release_event (m_release_event),
        .press_total   (m_press_total)
    );

    assign m_valid = m_valid_reg;

    // A result never reports a press and a release together.
    `SPD_ASSERT_NOW(a_one_event, aclk, aresetn, m_valid, !(m_press_event && m_release_event))
    // A press event always leaves the knob pressed.
    `SPD_ASSERT_NOW(a_press_state, aclk, aresetn, m_valid && m_press_event, m_is_pressed)
    // The press total steps by one exactly on a press event.
    `SPD_ASSERT_NEXT(a_total_step, aclk, aresetn, fire,
        m_press_total == $past(m_press_total) + 32'(m_press_event))
    // Input is only held off while both stages are full and the output stalls.
    `SPD_ASSERT_NOW(a_backpressure, aclk, aresetn, !s_ready, s1_valid_reg && m_valid && !m_ready)

endmodule

// ===== design/spd_classify.sv =====
// Combinational classification of a registered sample against idle and delta.
// Depends on spd_pkg.
module spd_classify (
    input  spd_pkg::sample_t sample,
    input  spd_pkg::sample_t idle_level,
    input  spd_pkg::delta_t  delta_level,
    input  logic             detect_enable,
    output spd_pkg::cmp_t    cmp
);

    spd_pkg::cmp_word_t d;
    spd_pkg::cmp_word_t d2;
    spd_pkg::cmp_word_t dl;
    spd_pkg::cmp_word_t dl2;
    spd_pkg::cmp_word_t dl_neg;
    logic               dl_is_neg;

    always_comb begin
        d         = spd_pkg::cmp_word_t'(sample) - spd_pkg::cmp_word_t'(idle_level);
        d2        = d <<< 1;
        dl        = spd_pkg::cmp_word_t'(delta_level);
        dl2       = dl <<< 1;
        dl_neg    = -dl;
        dl_is_neg = delta_level[spd_pkg::DELTA_BITS-1];

        cmp.active = detect_enable && (delta_level != '0);
        if (!dl_is_neg) begin
            cmp.in_range   = (d > dl_neg) && (d < dl2);
            cmp.above_one  = d > dl;
            cmp.below_half = d2 < dl;
        end else begin
            cmp.in_range   = (d < dl_neg) && (d > dl2);
            cmp.above_one  = d < dl;
            cmp.below_half = d2 > dl;
        end
    end

endmodule

// ===== design/spd_track.sv =====
// Debounce state (pressed flag, run counter, press total) and result register.
// Depends on spd_pkg.
module spd_track (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             fire,
    input  spd_pkg::cmp_t                    cmp,
    output logic                             is_pressed,
    output logic                             press_event,
    output logic                             release_event,
    output logic [spd_pkg::TOTAL_BITS-1:0]   press_total
);

    logic                           pressed_reg, pressed_next;
    logic [spd_pkg::RUN_BITS-1:0]   run_reg, run_next;
    logic [spd_pkg::TOTAL_BITS-1:0] total_reg, total_next;
    logic                           pev_reg, pev_next;
    logic                           rev_reg, rev_next;
    logic                           advance;

    always_comb begin
        pressed_next = pressed_reg;
        run_next     = run_reg;
        total_next   = total_reg;
        pev_next     = 1'b0;
        rev_next     = 1'b0;
        advance      = (!pressed_reg && cmp.above_one) || (pressed_reg && cmp.below_half);
        if (cmp.active && cmp.in_range) begin
            if (advance) begin
                run_next = run_reg + 1'b1;
                if (run_next > spd_pkg::RUN_LIMIT) begin
                    pressed_next = !pressed_reg;
                    if (!pressed_reg) begin
                        total_next = total_reg + 1'b1;
                        pev_next   = 1'b1;
                    end else begin
                        rev_next = 1'b1;
                    end
                end
            end else begin
                run_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg <= 1'b0;
            run_reg     <= '0;
            total_reg   <= '0;
            pev_reg     <= 1'b0;
            rev_reg     <= 1'b0;
        end else if (fire) begin
            pressed_reg <= pressed_next;
            run_reg     <= run_next;
            total_reg   <= total_next;
            pev_reg     <= pev_next;
            rev_reg     <= rev_next;
        end
    end

    // State only moves when a result is loaded, so it doubles as the payload.
    assign is_pressed    = pressed_reg;
    assign press_event   = pev_reg;
    assign release_event = rev_reg;
    assign press_total   = total_reg;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for strain_press_debouncer_core: directed and random
// sample streams checked against an in-bench predictor of the debounce logic.
// Depends on spd_pkg and the strain_press_debouncer_core RTL.
module testbench;
    import spd_pkg::*;

    // Index past the end of the register map; writes there must be dropped.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

    localparam int     RANDOM_ITEMS = 1400;
    localparam int     CYCLE_LIMIT  = 400000;
    // Pipeline is two deep; spare idle cycles follow before touching config.
    localparam int     DRAIN_CYCLES = 6;
    localparam longint SAMPLE_MIN   = -(longint'(1) << (SAMPLE_BITS - 1));
    localparam longint SAMPLE_MAX   = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint DELTA_MAX    = (longint'(1) << SAMPLE_BITS) - 1;
    localparam longint DELTA_MIN    = -(longint'(1) << SAMPLE_BITS);

    // What one sample is aimed at, in terms of the ratio (sample - idle) / delta.
    typedef enum {
        CLS_ABOVE,   // ratio in (1, 2): advances while released
        CLS_MID,     // ratio in [1/2, 1]: clears in either state
        CLS_BELOW,   // ratio in (-1, 1/2): advances while pressed
        CLS_OUT,     // ratio outside (-1, 2): dropped
        CLS_NOISE    // any bit pattern
    } sample_class_t;

    typedef struct packed {
        logic                  is_pressed;
        logic                  press_event;
        logic                  release_event;
        logic [TOTAL_BITS-1:0] press_total;
    } press_result_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                      aclk            = 1'b0;
    logic                      aresetn         = 1'b0;
    logic                      cfg_wr_en       = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index       = CFG_DETECT_ENABLE;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata       = '0;
    logic                      s_valid         = 1'b0;
    logic                      s_ready;
    sample_t                   s_sample        = '0;
    logic                      m_valid;
    logic                      m_ready         = 1'b0;
    logic                      m_is_pressed;
    logic                      m_press_event;
    logic                      m_release_event;
    logic [TOTAL_BITS-1:0]     m_press_total;

    strain_press_debouncer_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample        (s_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_pressed    (m_is_pressed),
        .m_press_event   (m_press_event),
        .m_release_event (m_release_event),
        .m_press_total   (m_press_total)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor state: register mirror plus the debounce state
    // ------------------------------------------------------------------
    logic                  cfg_enable    = 1'b0;
    sample_t               cfg_idle      = '0;
    delta_t                cfg_delta     = '0;
    logic                  pressed_state = 1'b0;
    logic [RUN_BITS-1:0]   run_length    = '0;
    logic [TOTAL_BITS-1:0] press_count   = '0;

    press_result_t pending_results[$];
    press_result_t next_result;
    int            error_count = 0;
    int            cycle_count = 0;

    // Sender burst shaping
    int burst_left = 0;
    int gap_len    = 0;

    // Advance the debounce state by one accepted sample and return the result
    // the block must produce for it.
    function automatic press_result_t predict_press(sample_t smp);
        longint        d;
        longint        dl;
        logic          in_range;
        logic          above_one;
        logic          below_half;
        press_result_t r;
        dl              = longint'(cfg_delta);
        r.press_event   = 1'b0;
        r.release_event = 1'b0;
        // Disabled or zero delta: nothing moves, state is just reported.
        if (cfg_enable && dl != 0) begin
            d = longint'(smp) - longint'(cfg_idle);
            // Compare d against delta without dividing; a negative delta flips
            // every inequality.
            if (dl > 0) begin
                in_range   = (d > -dl) && (d < 2 * dl);
                above_one  = d > dl;
                below_half = 2 * d < dl;
            end else begin
                in_range   = (d < -dl) && (d > 2 * dl);
                above_one  = d < dl;
                below_half = 2 * d > dl;
            end
            if (in_range) begin
                if ((!pressed_state && above_one) || (pressed_state && below_half)) begin
                    // 8-bit run counter wraps; a toggle does not clear it.
                    run_length = run_length + 1'b1;
                    if (run_length > RUN_LIMIT) begin
                        if (!pressed_state) begin
                            pressed_state = 1'b1;
                            press_count   = press_count + 1'b1;
                            r.press_event = 1'b1;
                        end else begin
                            pressed_state   = 1'b0;
                            r.release_event = 1'b1;
                        end
                    end
                end else begin
                    run_length = '0;
                end
            end
        end
        r.is_pressed  = pressed_state;
        r.press_total = press_count;
        return r;
    endfunction

    function automatic longint pick(longint lo, longint hi);
        if (hi <= lo) begin
            return lo;
        end
        return lo + longint'($urandom_range(32'(hi - lo)));
    endfunction

    // Build a sample of the given class under the current calibration. Targets
    // that do not fit the sample width fall back to a random pattern.
    function automatic sample_t make_sample(sample_class_t cls);
        longint dl;
        longint m;
        longint dp;
        longint s;
        dl = longint'(cfg_delta);
        m  = (dl < 0) ? -dl : dl;
        if (m == 0 || cls == CLS_NOISE) begin
            return sample_t'($urandom);
        end
        case (cls)
            CLS_ABOVE: dp = pick(m + 1, 2 * m - 1);
            CLS_MID:   dp = pick((m + 1) / 2, m);
            CLS_BELOW: dp = pick(-m + 1, (m - 1) / 2);
            default:   dp = $urandom_range(1) ? 2 * m + pick(0, m) : -m - pick(0, m);
        endcase
        s = longint'(cfg_idle) + ((dl < 0) ? -dp : dp);
        if (s < SAMPLE_MIN || s > SAMPLE_MAX) begin
            return sample_t'($urandom);
        end
        return sample_t'(s);
    endfunction

    // ------------------------------------------------------------------
    // Sender: one transaction per call, valid held across back-to-back items
    // ------------------------------------------------------------------
    task automatic send_sample(sample_t smp);
        @(negedge aclk);
        s_valid  <= 1'b1;
        s_sample <= smp;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_press(smp));
        // Bursts of random length; at the end of a burst, maybe a gap.
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_len    = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_len != 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap_len - 1) @(negedge aclk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_offset(longint d);
        send_sample(sample_t'(longint'(cfg_idle) + d));
    endtask

    // Stop sending and wait until every result is back and the pipe is empty.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_DETECT_ENABLE: cfg_enable = data[0];
            CFG_IDLE_LEVEL:    cfg_idle   = data[SAMPLE_BITS-1:0];
            CFG_DELTA_LEVEL:   cfg_delta  = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Unused upper data bits carry junk to check that they are masked.
    task automatic configure(logic en, sample_t idle, delta_t delta);
        settle();
        write_reg(CFG_DETECT_ENABLE, {24'($urandom), en});
        write_reg(CFG_IDLE_LEVEL, {1'($urandom), idle});
        write_reg(CFG_DELTA_LEVEL, delta);
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready follows its own pattern of free-run, random and
    // sparse stretches
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int stall_left = 0;

    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(2);
            stall_left = $urandom_range(16, 120);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(1));
            default: m_ready <= ($urandom_range(3) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("[%0t] unexpected result: expected none, actual pressed=%0d total=%0d",
                         $time, m_is_pressed, m_press_total);
                error_count++;
            end else begin
                next_result = pending_results.pop_front();
                if (m_is_pressed !== next_result.is_pressed) begin
                    $display("[%0t] is_pressed mismatch: expected %0d, actual %0d",
                             $time, next_result.is_pressed, m_is_pressed);
                    error_count++;
                end
                if (m_press_event !== next_result.press_event) begin
                    $display("[%0t] press_event mismatch: expected %0d, actual %0d",
                             $time, next_result.press_event, m_press_event);
                    error_count++;
                end
                if (m_release_event !== next_result.release_event) begin
                    $display("[%0t] release_event mismatch: expected %0d, actual %0d",
                             $time, next_result.release_event, m_release_event);
                    error_count++;
                end
                if (m_press_total !== next_result.press_total) begin
                    $display("[%0t] press_total mismatch: expected %0d, actual %0d",
                             $time, next_result.press_total, m_press_total);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Inert block: disabled, then enabled with zero delta, then a write to
    // an index past the register map.
    task automatic test_inert();
        configure(1'b0, '0, delta_t'(1000));
        send_sample(sample_t'(SAMPLE_MAX));
        send_sample(sample_t'(SAMPLE_MIN));
        configure(1'b1, '0, '0);
        send_offset(1500);
        settle();
        write_reg(CFG_UNUSED, '1);
        send_offset(1500);
    endtask

    // Press, clear while pressed, release, then the immediate re-toggles
    // caused by the run counter surviving a toggle.
    task automatic test_press_release();
        configure(1'b1, sample_t'(100), delta_t'(1000));
        repeat (3) send_offset(1500);
        send_offset(1500);
        repeat (3) send_offset(0);
        send_offset(1500);
        send_offset(200);
    endtask

    // Exact boundaries of the range window and of ratio 1.
    task automatic test_range_edges();
        configure(1'b1, sample_t'(-50), delta_t'(1000));
        send_offset(1000);
        send_offset(1999);
        send_offset(2000);
        send_offset(1999);
        send_offset(1999);
        send_offset(-1000);
        send_offset(-999);
    endtask

    // Negative delta mirrors every compare, including the half boundary.
    task automatic test_negative_delta();
        configure(1'b1, '0, delta_t'(-1000));
        repeat (3) send_offset(-1500);
        send_offset(-2000);
        send_offset(1000);
        send_offset(-500);
        send_offset(-499);
    endtask

    // Widest spans: sample and idle at opposite ends, delta at both extremes.
    task automatic test_extremes();
        configure(1'b1, sample_t'(SAMPLE_MIN), delta_t'(DELTA_MAX));
        send_sample(sample_t'(SAMPLE_MAX));
        send_sample(sample_t'(SAMPLE_MIN));
        send_sample(sample_t'(SAMPLE_MAX));
        configure(1'b1, sample_t'(SAMPLE_MAX), delta_t'(DELTA_MIN));
        send_sample(sample_t'(SAMPLE_MIN));
        send_sample(sample_t'(SAMPLE_MAX));
        send_sample(sample_t'(SAMPLE_MIN));
    endtask

    // Alternating samples advance on every item, toggling each time past the limit,
    // until the 8-bit run counter wraps and toggles pause until it passes again.
    task automatic test_run_wrap();
        logic want_high;
        configure(1'b1, '0, delta_t'(100));
        send_offset(80);
        repeat (262) begin
            want_high = !pressed_state;
            send_offset(want_high ? 150 : 0);
        end
    endtask

    task automatic random_config();
        logic    en;
        sample_t idle;
        delta_t  delta;
        en = ($urandom_range(19) != 0);
        case ($urandom_range(11))
            0:       delta = delta_t'(DELTA_MAX);
            1:       delta = delta_t'(-DELTA_MAX);
            2:       delta = delta_t'(DELTA_MIN);
            3:       delta = delta_t'($urandom_range(1) ? pick(1, 3) : -pick(1, 3));
            4:       delta = '0;
            5:       delta = delta_t'($urandom);
            default: delta = delta_t'($urandom_range(1) ? pick(2, 5000) : -pick(2, 5000));
        endcase
        case ($urandom_range(9))
            0:       idle = sample_t'(SAMPLE_MIN);
            1:       idle = sample_t'(SAMPLE_MAX);
            default: idle = sample_t'($urandom);
        endcase
        configure(en, idle, delta);
    endtask

    // Phases of random calibration; within each, runs of samples of one class,
    // biased toward the class that advances the debounce counter.
    task automatic test_random();
        int            counted;
        int            phase_len;
        int            sent;
        int            run_len;
        int            roll;
        sample_class_t cls;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            random_config();
            phase_len = (cfg_enable && cfg_delta != 0) ? $urandom_range(60, 220)
                                                       : $urandom_range(5, 30);
            sent = 0;
            while (sent < phase_len) begin
                roll = $urandom_range(99);
                if (roll < 55) begin
                    cls     = pressed_state ? CLS_BELOW : CLS_ABOVE;
                    run_len = $urandom_range(1, 5);
                end else if (roll < 70) begin
                    cls     = CLS_MID;
                    run_len = $urandom_range(1, 3);
                end else if (roll < 80) begin
                    cls     = pressed_state ? CLS_ABOVE : CLS_BELOW;
                    run_len = $urandom_range(1, 3);
                end else if (roll < 88) begin
                    cls     = CLS_OUT;
                    run_len = $urandom_range(1, 3);
                end else begin
                    cls     = CLS_NOISE;
                    run_len = $urandom_range(1, 4);
                end
                repeat (run_len) begin
                    send_sample(make_sample(cls));
                    sent++;
                    if (cfg_enable && cfg_delta != 0) begin
                        counted++;
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, then each test in turn, then drain and report
    // ------------------------------------------------------------------
    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        test_inert();
        test_press_release();
        test_range_edges();
        test_negative_delta();
        test_extremes();
        test_run_wrap();
        test_random();
        settle();
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
